FILE: hw/rtl/gbc_pkg.sv
// Shared types, constants and helper functions for the bipartite graph checker.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package gbc_pkg;

	// Graph size and derived widths.
	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int ADJ_DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int ADJ_AW = $clog2(ADJ_DEPTH);
	localparam int CMP_W = 8;

	// Fixed field widths of the ports.
	localparam int ACTION_W = 2;
	localparam int VFIELD_W = 4;
	localparam int KIND_W = 2;
	localparam int COMPS_W = 5;
	localparam int VCOUNT_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;
	localparam int EDGE_W = 2;
	localparam int COLOR_W = 2;
	localparam int RES_W = 2;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENEMY_FAILS = 2'd1;

	// Actions carried by an input transaction.
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd2;

	// Edge kinds as given on the input.
	localparam logic [KIND_W-1:0] IKIND_FRIEND = 2'd0;
	localparam logic [KIND_W-1:0] IKIND_ENEMY = 2'd1;

	// Edge codes as stored in the adjacency memory.
	localparam logic [EDGE_W-1:0] EDGE_NONE = 2'd0;
	localparam logic [EDGE_W-1:0] EDGE_FRIEND = 2'd1;
	localparam logic [EDGE_W-1:0] EDGE_ENEMY = 2'd2;

	// Vertex colours.
	localparam logic [COLOR_W-1:0] COL_NONE = 2'd0;
	localparam logic [COLOR_W-1:0] COL_A = 2'd1;
	localparam logic [COLOR_W-1:0] COL_B = 2'd2;

	// Result codes held by the controller until the result is delivered.
	localparam logic [RES_W-1:0] RES_OK = 2'd0;
	localparam logic [RES_W-1:0] RES_RANGE = 2'd1;
	localparam logic [RES_W-1:0] RES_FAIL = 2'd2;
	localparam logic [RES_W-1:0] RES_PASS = 2'd3;

	// Scan modes of the matrix walker.
	localparam logic SCAN_ENEMY = 1'b0;
	localparam logic SCAN_ROW = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic clear_graph;
		logic wr_fwd;
		logic wr_rev;
		logic scan_issue;
		logic scan_mode;
		logic color_init;
		logic outer_next;
		logic comp_start;
		logic comp_done;
		logic pop;
		logic out_load;
		logic [RES_W-1:0] res;
	} gbc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic range_bad;
		logic kind_writes;
		logic strict;
		logic n_zero;
		logic col_last;
		logic row_last;
		logic enemy_any;
		logic conflict_any;
		logic outer_end;
		logic outer_visited;
		logic stack_empty;
	} gbc_stat_t;

	// Linear address of a matrix entry.
	function automatic logic [ADJ_AW-1:0] adj_addr(input logic [VIDX_W-1:0] row,
			input logic [VIDX_W-1:0] col);
		adj_addr = ADJ_AW'(row) * ADJ_AW'(MAX_VERTICES) + ADJ_AW'(col);
	endfunction

	// The colour opposite to the given one.
	function automatic logic [COLOR_W-1:0] other_color(input logic [COLOR_W-1:0] c);
		other_color = (c == COL_A) ? COL_B : COL_A;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gbc_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered data.
// No dependencies.
`default_nettype none

module gbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read data registered; a read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gbc_ctrl.sv
// Controller state machine of the bipartite graph checker.
// Depends on gbc_pkg; drives the datapath through gbc_cmd_t and reads gbc_stat_t.
`default_nettype none

module gbc_ctrl
	import gbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire gbc_stat_t stat,
	output gbc_cmd_t       cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_INS_REV = 4'd2;
	localparam logic [3:0] S_SCAN = 4'd3;
	localparam logic [3:0] S_SCAN_END = 4'd4;
	localparam logic [3:0] S_CINIT = 4'd5;
	localparam logic [3:0] S_OUTER = 4'd6;
	localparam logic [3:0] S_ROW = 4'd7;
	localparam logic [3:0] S_ROW_END = 4'd8;
	localparam logic [3:0] S_POP = 4'd9;
	localparam logic [3:0] S_RESULT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [RES_W-1:0] res_q;
	logic [RES_W-1:0] res_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		res_d = res_q;
		cmd = '0;
		cmd.res = res_q;
		cmd.scan_mode = SCAN_ENEMY;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_d = RES_OK;
				case (stat.action)
					ACT_CLEAR: begin
						cmd.clear_graph = 1'b1;
						state_d = S_RESULT;
					end
					ACT_INSERT: begin
						if (stat.range_bad) begin
							res_d = RES_RANGE;
							state_d = S_RESULT;
						end else if (stat.kind_writes) begin
							cmd.wr_fwd = 1'b1;
							state_d = S_INS_REV;
						end else begin
							state_d = S_RESULT;
						end
					end
					ACT_CHECK: begin
						if (stat.strict && !stat.n_zero) begin
							state_d = S_SCAN;
						end else begin
							state_d = S_CINIT;
						end
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_INS_REV: begin
				cmd.wr_rev = 1'b1;
				state_d = S_RESULT;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				cmd.scan_mode = SCAN_ENEMY;
				if (stat.col_last && stat.row_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				if (stat.enemy_any) begin
					res_d = RES_FAIL;
					state_d = S_RESULT;
				end else begin
					state_d = S_CINIT;
				end
			end
			S_CINIT: begin
				cmd.color_init = 1'b1;
				state_d = S_OUTER;
			end
			S_OUTER: begin
				if (stat.outer_end) begin
					res_d = RES_PASS;
					state_d = S_RESULT;
				end else if (stat.outer_visited) begin
					cmd.outer_next = 1'b1;
				end else begin
					cmd.comp_start = 1'b1;
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				cmd.scan_issue = 1'b1;
				cmd.scan_mode = SCAN_ROW;
				if (stat.col_last) begin
					state_d = S_ROW_END;
				end
			end
			S_ROW_END: begin
				cmd.scan_mode = SCAN_ROW;
				if (stat.conflict_any) begin
					res_d = RES_FAIL;
					state_d = S_RESULT;
				end else if (stat.stack_empty) begin
					cmd.comp_done = 1'b1;
					state_d = S_OUTER;
				end else begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_ROW;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result code registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q <= RES_OK;
		end else begin
			state_q <= state_d;
			res_q <= res_d;
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted transaction did not start execution");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an undelivered result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result transaction withdrawn before it was taken");

endmodule

`default_nettype wire

FILE: hw/rtl/gbc_dp.sv
// Datapath of the bipartite graph checker: adjacency memory, edge valid bits, colours,
// depth-first stack, scan counters and result registers. Depends on gbc_pkg and gbc_ram.
`default_nettype none

module gbc_dp
	import gbc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gbc_cmd_t              cmd,
	output gbc_stat_t                  stat,
	input  wire logic [ACTION_W-1:0]   action,
	input  wire logic [VFIELD_W-1:0]   first_vertex,
	input  wire logic [VFIELD_W-1:0]   second_vertex,
	input  wire logic [KIND_W-1:0]     edge_kind,
	input  wire logic [VCOUNT_W-1:0]   vertex_count,
	input  wire logic                  enemy_edge_fails,
	output logic                       status,
	output logic                       is_bipartite,
	output logic [COMPS_W-1:0]         component_count
);

	// Latched transaction fields.
	logic [ACTION_W-1:0] action_q;
	logic [VFIELD_W-1:0] first_q;
	logic [VFIELD_W-1:0] second_q;
	logic [KIND_W-1:0] kind_q;
	logic [CNT_W-1:0] n_q;
	logic strict_q;
	logic [CNT_W-1:0] n_eff;

	// Adjacency storage.
	logic [ADJ_DEPTH-1:0] adj_valid_q;
	logic adj_we;
	logic [ADJ_AW-1:0] adj_waddr;
	logic [EDGE_W-1:0] adj_wdata;
	logic [ADJ_AW-1:0] adj_raddr;
	logic [EDGE_W-1:0] adj_rdata;

	// Matrix walker and its read stage.
	logic [VIDX_W-1:0] r_q;
	logic [VIDX_W-1:0] c_q;
	logic col_last;
	logic row_last;
	logic vld_s1;
	logic mode_s1;
	logic [VIDX_W-1:0] c_s1;
	logic adj_vld_s1;
	logic [EDGE_W-1:0] edge_s1;

	// Colouring state.
	logic [COLOR_W-1:0] col_q [MAX_VERTICES];
	logic [VIDX_W-1:0] stk_v_q [MAX_VERTICES];
	logic [COLOR_W-1:0] stk_c_q [MAX_VERTICES];
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] depth_m1;
	logic [VIDX_W-1:0] cur_q;
	logic [COLOR_W-1:0] cur_col_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] comps_q;
	logic enemy_q;
	logic conflict_q;
	logic [VIDX_W-1:0] col_raddr;
	logic [COLOR_W-1:0] col_rd;
	logic row_hit;
	logic push;
	logic clash;
	logic enemy_hit;

	// Output registers.
	logic status_q;
	logic bip_q;
	logic [COMPS_W-1:0] comps_out_q;

	// Vertex count in use, limited to the matrix size.
	assign n_eff = (CMP_W'(vertex_count) > CMP_W'(MAX_VERTICES)) ?
		CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count);

	// Transaction fields are captured on acceptance.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q <= action;
			first_q <= first_vertex;
			second_q <= second_vertex;
			kind_q <= edge_kind;
			n_q <= n_eff;
			strict_q <= enemy_edge_fails;
		end
	end

	// Write port: forward entry first, mirrored entry in the following cycle.
	assign adj_we = cmd.wr_fwd || cmd.wr_rev;
	assign adj_waddr = cmd.wr_rev ? adj_addr(VIDX_W'(second_q), VIDX_W'(first_q)) :
		adj_addr(VIDX_W'(first_q), VIDX_W'(second_q));
	assign adj_wdata = (kind_q == IKIND_FRIEND) ? EDGE_FRIEND : EDGE_ENEMY;
	assign adj_raddr = (cmd.scan_mode == SCAN_ROW) ? adj_addr(cur_q, c_q) : adj_addr(r_q, c_q);

	gbc_ram #(
		.WIDTH(EDGE_W),
		.DEPTH(ADJ_DEPTH)
	) u_adj_ram (
		.clk(clk),
		.we(adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	// Per-entry valid bits: an entry never written since the last clear reads as no edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_valid_q <= '0;
		end else if (cmd.clear_graph) begin
			adj_valid_q <= '0;
		end else if (adj_we) begin
			adj_valid_q[adj_waddr] <= 1'b1;
		end
	end

	// Walker counters: columns within a row, rows for the enmity scan.
	assign col_last = (CNT_W'(c_q) == n_q - CNT_W'(1));
	assign row_last = (CNT_W'(r_q) == n_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (cmd.load_in) begin
			r_q <= '0;
			c_q <= '0;
		end else if (cmd.scan_issue) begin
			if (col_last) begin
				c_q <= '0;
				if (cmd.scan_mode == SCAN_ENEMY) begin
					r_q <= row_last ? '0 : r_q + VIDX_W'(1);
				end
			end else begin
				c_q <= c_q + VIDX_W'(1);
			end
		end
	end

	// Read stage: tracks the entry whose data leaves the memory this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			mode_s1 <= cmd.scan_mode;
			c_s1 <= c_q;
			adj_vld_s1 <= adj_valid_q[adj_raddr];
		end
	end

	assign edge_s1 = adj_vld_s1 ? adj_rdata : EDGE_NONE;

	// Edge evaluation against the colours.
	assign col_raddr = (vld_s1 && mode_s1 == SCAN_ROW) ? c_s1 : VIDX_W'(i_q);
	assign col_rd = col_q[col_raddr];
	assign row_hit = vld_s1 && (mode_s1 == SCAN_ROW) && (edge_s1 == EDGE_FRIEND);
	assign push = row_hit && (col_rd == COL_NONE);
	assign clash = row_hit && (col_rd == cur_col_q);
	assign enemy_hit = vld_s1 && (mode_s1 == SCAN_ENEMY) && (edge_s1 == EDGE_ENEMY);

	// Vertex colours.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				col_q[k] <= COL_NONE;
			end
		end else if (cmd.color_init) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				col_q[k] <= COL_NONE;
			end
		end else begin
			if (cmd.comp_start) begin
				col_q[VIDX_W'(i_q)] <= COL_A;
			end
			if (push) begin
				col_q[c_s1] <= other_color(cur_col_q);
			end
		end
	end

	// Stack entries: vertex and the colour it was given.
	assign depth_m1 = depth_q - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (push) begin
			stk_v_q[depth_q[VIDX_W-1:0]] <= c_s1;
			stk_c_q[depth_q[VIDX_W-1:0]] <= other_color(cur_col_q);
		end
	end

	// Stack depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.color_init) begin
			depth_q <= '0;
		end else if (push) begin
			depth_q <= depth_q + CNT_W'(1);
		end else if (cmd.pop) begin
			depth_q <= depth_m1;
		end
	end

	// Vertex being expanded and its colour.
	always_ff @(posedge clk) begin
		if (cmd.comp_start) begin
			cur_q <= VIDX_W'(i_q);
			cur_col_q <= COL_A;
		end else if (cmd.pop) begin
			cur_q <= stk_v_q[depth_m1[VIDX_W-1:0]];
			cur_col_q <= stk_c_q[depth_m1[VIDX_W-1:0]];
		end
	end

	// Outer vertex index, component count and sticky failure flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			comps_q <= '0;
			enemy_q <= 1'b0;
			conflict_q <= 1'b0;
		end else begin
			if (cmd.color_init) begin
				i_q <= '0;
			end else if (cmd.outer_next || cmd.comp_done) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (cmd.load_in) begin
				comps_q <= '0;
			end else if (cmd.comp_done) begin
				comps_q <= comps_q + CNT_W'(1);
			end
			if (cmd.load_in) begin
				enemy_q <= 1'b0;
				conflict_q <= 1'b0;
			end else begin
				if (enemy_hit) begin
					enemy_q <= 1'b1;
				end
				if (clash) begin
					conflict_q <= 1'b1;
				end
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= (cmd.res == RES_RANGE);
			bip_q <= (cmd.res == RES_PASS);
			comps_out_q <= COMPS_W'(comps_q);
		end
	end

	assign status = status_q;
	assign is_bipartite = bip_q;
	assign component_count = comps_out_q;

	// Status to the controller.
	always_comb begin
		stat.action = action_q;
		stat.range_bad = (CMP_W'(first_q) >= CMP_W'(n_q)) || (CMP_W'(second_q) >= CMP_W'(n_q));
		stat.kind_writes = (kind_q == IKIND_FRIEND) || (kind_q == IKIND_ENEMY);
		stat.strict = strict_q;
		stat.n_zero = (n_q == '0);
		stat.col_last = col_last;
		stat.row_last = row_last;
		stat.enemy_any = enemy_q || enemy_hit;
		stat.conflict_any = conflict_q || clash;
		stat.outer_end = (i_q == n_q);
		stat.outer_visited = (col_rd != COL_NONE);
		stat.stack_empty = (depth_q == '0) && !push;
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (depth_q < CNT_W'(MAX_VERTICES)))
		else $error("stack push beyond its depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (depth_q != '0))
		else $error("stack pop while empty");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> (CNT_W'(c_q) < n_q))
		else $error("matrix column read beyond the vertices in use");

endmodule

`default_nettype wire

FILE: hw/rtl/graph_bipartite_checker_top.sv
// Top level of the bipartite graph checker: configuration registers and the
// controller and datapath instances. Depends on gbc_pkg, gbc_ctrl and gbc_dp.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   action, first_vertex, second_vertex, edge_kind
// output    out        out_valid / out_ready status, is_bipartite, component_count
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction is processed at a time. A check walks the adjacency memory one entry
// per cycle while a scan runs, through its single read port, with an extra walk over the
// whole matrix in use first when enmity edges are checked.
// Reset clears the edge valid bits, colours and control state at once; there is no sweep.
// A new transaction is accepted while an earlier result still waits on a stalled output.
`default_nettype none

module graph_bipartite_checker_top
	import gbc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ACTION_W-1:0]   action,
	input  wire logic [VFIELD_W-1:0]   first_vertex,
	input  wire logic [VFIELD_W-1:0]   second_vertex,
	input  wire logic [KIND_W-1:0]     edge_kind,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       status,
	output logic                       is_bipartite,
	output logic [COMPS_W-1:0]         component_count,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [VCOUNT_W-1:0] vertex_count_q;
	logic enemy_fails_q;
	gbc_cmd_t cmd;
	gbc_stat_t stat;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
			enemy_fails_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VERTEX_COUNT: vertex_count_q <= cfg_data[VCOUNT_W-1:0];
				CFG_ENEMY_FAILS: enemy_fails_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencing.
	gbc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	// Storage and arithmetic.
	gbc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.action(action),
		.first_vertex(first_vertex),
		.second_vertex(second_vertex),
		.edge_kind(edge_kind),
		.vertex_count(vertex_count_q),
		.enemy_edge_fails(enemy_fails_q),
		.status(status),
		.is_bipartite(is_bipartite),
		.component_count(component_count)
	);

endmodule

`default_nettype wire

FILE: verif/graph_bipartite_checker_top_tb.sv
// Self-checking testbench for graph_bipartite_checker_top: edge inserts, clears and
// bipartite checks are predicted by a local graph model and compared on every result.
// Depends on gbc_pkg and the RTL of graph_bipartite_checker_top.
`default_nettype none

module graph_bipartite_checker_top_tb;
	import gbc_pkg::*;

	// Codes that the package leaves unnamed.
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [KIND_W-1:0] IKIND_OTHER = 2'd2;
	localparam logic [KIND_W-1:0] IKIND_SPARE = 2'd3;

	localparam int CYCLE_LIMIT = 6000000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 236;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VFIELD_W-1:0] first;
		logic [VFIELD_W-1:0] second;
		logic [KIND_W-1:0]   kind;
		logic                hold;
	} request_t;

	typedef struct packed {
		logic               status;
		logic               bip;
		logic [COMPS_W-1:0] comps;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ACTION_W-1:0] action = ACT_CLEAR;
	logic [VFIELD_W-1:0] first_vertex = '0;
	logic [VFIELD_W-1:0] second_vertex = '0;
	logic [KIND_W-1:0] edge_kind = IKIND_FRIEND;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic is_bipartite;
	logic [COMPS_W-1:0] component_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_VERTEX_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Local copy of the graph, the colouring and the configuration.
	logic [EDGE_W-1:0] edge_mem [MAX_VERTICES][MAX_VERTICES];
	logic [COLOR_W-1:0] shade [MAX_VERTICES];
	logic [VCOUNT_W-1:0] vertex_limit = VCOUNT_RESET;
	logic enemy_strict = 1'b0;

	request_t pending_requests [$];
	verdict_t awaited_verdicts [$];
	request_t current_request;
	int requests_queued = 0;
	int requests_sent = 0;
	int verdicts_seen = 0;
	int error_count = 0;
	int cycle_count = 0;
	int sender_idle = 0;
	int receiver_stall = 0;

	int phase_sizes [PHASES] = '{16, 4, 8, 2, 1, 12, 16, 6};
	int phase_strict [PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0};
	int idle_send [4] = '{0, 64, 0, 10};
	int idle_recv [4] = '{0, 0, 64, 10};

	graph_bipartite_checker_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.first_vertex(first_vertex),
		.second_vertex(second_vertex),
		.edge_kind(edge_kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.is_bipartite(is_bipartite),
		.component_count(component_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic int active_vertices();
		return (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_limit);
	endfunction

	function automatic void wipe_edges();
		for (int i = 0; i < MAX_VERTICES; i++)
			for (int j = 0; j < MAX_VERTICES; j++)
				edge_mem[i][j] = EDGE_NONE;
	endfunction

	// Depth-first two-colouring of one component over friendship edges.
	function automatic bit colour_component(input int start, input int n);
		int dfs_stack [MAX_VERTICES];
		int depth;
		int cur;
		dfs_stack[0] = start;
		depth = 1;
		shade[start] = COL_A;
		while (depth > 0) begin
			depth--;
			cur = dfs_stack[depth];
			for (int v = 0; v < n; v++) begin
				if (edge_mem[cur][v] != EDGE_FRIEND)
					continue;
				if (shade[v] == COL_NONE) begin
					shade[v] = (shade[cur] == COL_A) ? COL_B : COL_A;
					if (depth < MAX_VERTICES) begin
						dfs_stack[depth] = v;
						depth++;
					end
				end else if (shade[v] == shade[cur]) begin
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	// Whole-graph check: strict enmity scan first, then components by lowest vertex.
	function automatic logic check_graph(input int n, output logic [COMPS_W-1:0] comps);
		comps = '0;
		if (enemy_strict) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					if (edge_mem[i][j] == EDGE_ENEMY)
						return 1'b0;
		end
		for (int i = 0; i < MAX_VERTICES; i++)
			shade[i] = COL_NONE;
		for (int i = 0; i < n; i++) begin
			if (shade[i] != COL_NONE)
				continue;
			if (!colour_component(i, n))
				return 1'b0;
			comps++;
		end
		return 1'b1;
	endfunction

	// Applies one transaction to the local graph and gives the result it should produce.
	function automatic verdict_t graph_verdict(input request_t r);
		verdict_t v;
		int n;
		logic [EDGE_W-1:0] code;
		v = '0;
		n = active_vertices();
		case (r.action)
			ACT_CLEAR: begin
				wipe_edges();
			end
			ACT_INSERT: begin
				if (int'(r.first) >= n || int'(r.second) >= n) begin
					v.status = 1'b1;
				end else if (r.kind == IKIND_FRIEND || r.kind == IKIND_ENEMY) begin
					code = (r.kind == IKIND_FRIEND) ? EDGE_FRIEND : EDGE_ENEMY;
					edge_mem[r.first][r.second] = code;
					edge_mem[r.second][r.first] = code;
				end
			end
			ACT_CHECK: begin
				v.bip = check_graph(n, v.comps);
			end
			default: ;
		endcase
		return v;
	endfunction

	// Driver: feeds the input channel from the pending queue and predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_CLEAR;
			first_vertex <= '0;
			second_vertex <= '0;
			edge_kind <= IKIND_FRIEND;
		end else begin
			if (in_valid && in_ready) begin
				awaited_verdicts.insert(awaited_verdicts.size(),
					graph_verdict(current_request));
				requests_sent++;
			end
			if (!in_valid || in_ready) begin
				// A held transaction waits until every earlier result has come back.
				if (pending_requests.size() != 0 &&
						!(pending_requests[0].hold && verdicts_seen != requests_sent) &&
						$urandom_range(0, 99) >= sender_idle) begin
					current_request = pending_requests.pop_front();
					in_valid <= 1'b1;
					action <= current_request.action;
					first_vertex <= current_request.first;
					second_vertex <= current_request.second;
					edge_kind <= current_request.kind;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each result with the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin : monitor
		verdict_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_verdicts.size() == 0) begin
					report_mismatch("result transaction with no prediction waiting");
				end else begin
					want = awaited_verdicts.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %b, predicted %b",
							status, want.status));
					if (is_bipartite !== want.bip)
						report_mismatch($sformatf("is_bipartite %b, predicted %b",
							is_bipartite, want.bip));
					if (component_count !== want.comps)
						report_mismatch($sformatf("component_count %0d, predicted %0d",
							component_count, want.comps));
					verdicts_seen <= verdicts_seen + 1;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_stall);
		end
	end

	task automatic queue_request(input logic [ACTION_W-1:0] act, input logic [VFIELD_W-1:0] a,
			input logic [VFIELD_W-1:0] b, input logic [KIND_W-1:0] k, input logic hold);
		request_t r;
		r.action = act;
		r.first = a;
		r.second = b;
		r.kind = k;
		r.hold = hold;
		pending_requests.insert(pending_requests.size(), r);
		requests_queued++;
	endtask

	function automatic logic [VFIELD_W-1:0] any_vertex(input int n);
		return (n == 0) ? VFIELD_W'($urandom_range(0, 15)) : VFIELD_W'($urandom_range(0, n - 1));
	endfunction

	// One graph built from a random two-sided split, then checked. A peaceful graph gets
	// cross-side friendships only, noise aside; else same-side friends and enemies creep in.
	task automatic queue_burst(input int n);
		logic [MAX_VERTICES-1:0] side;
		logic [VFIELD_W-1:0] a;
		logic [VFIELD_W-1:0] b;
		logic [KIND_W-1:0] k;
		logic peaceful;
		int inserts;
		int dice;
		side = MAX_VERTICES'($urandom);
		peaceful = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 7)
			queue_request(ACT_CLEAR, VFIELD_W'($urandom), VFIELD_W'($urandom),
				KIND_W'($urandom), 1'b0);
		inserts = $urandom_range(0, 2 * n + 1);
		repeat (inserts) begin
			dice = $urandom_range(0, 99);
			if (dice < 8) begin
				// Noise: any action, any indices, any kind.
				queue_request(ACTION_W'($urandom), VFIELD_W'($urandom), VFIELD_W'($urandom),
					KIND_W'($urandom), 1'b0);
			end else begin
				a = any_vertex(n);
				b = any_vertex(n);
				if (side[a] != side[b])
					k = (peaceful || dice < 85) ? IKIND_FRIEND : IKIND_ENEMY;
				else if (peaceful)
					k = IKIND_OTHER;
				else if (dice < 25)
					k = IKIND_FRIEND;
				else if (dice < 75)
					k = IKIND_ENEMY;
				else
					k = IKIND_SPARE;
				queue_request(ACT_INSERT, a, b, k, 1'b0);
			end
		end
		queue_request(ACT_CHECK, VFIELD_W'($urandom), VFIELD_W'($urandom), KIND_W'($urandom),
			$urandom_range(0, 49) == 0);
	endtask

	// Waits until every queued transaction has had its result.
	task automatic settle();
		while (verdicts_seen != requests_queued)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_VERTEX_COUNT)
			vertex_limit = value;
		else if (idx == CFG_ENEMY_FAILS)
			enemy_strict = value[0];
	endtask

	task automatic configure(input int count, input int strict);
		settle();
		write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(count));
		write_register(CFG_ENEMY_FAILS, CFG_DATA_W'(strict));
	endtask

	// Run watchdog.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("graph_bipartite_checker_top_tb failed");
		$finish;
	end

	// Stimulus: reset, a directed part, then random phases over several settings.
	initial begin
		wipe_edges();
		for (int i = 0; i < MAX_VERTICES; i++)
			shade[i] = COL_NONE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty graph, extreme indices, overwrite, ignored kinds and the unused action.
		queue_request(ACT_CLEAR, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);
		queue_request(ACT_CHECK, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);
		queue_request(ACT_INSERT, 4'd0, 4'd15, IKIND_FRIEND, 1'b0);
		queue_request(ACT_INSERT, 4'd15, 4'd0, IKIND_ENEMY, 1'b0);
		queue_request(ACT_INSERT, 4'd3, 4'd5, IKIND_OTHER, 1'b0);
		queue_request(ACT_INSERT, 4'd4, 4'd6, IKIND_SPARE, 1'b0);
		queue_request(ACT_UNUSED, 4'd15, 4'd15, IKIND_SPARE, 1'b0);
		queue_request(ACT_INSERT, 4'd0, 4'd15, IKIND_FRIEND, 1'b0);
		queue_request(ACT_CHECK, 4'd15, 4'd15, IKIND_SPARE, 1'b1);
		// A friendship self loop is a colouring conflict.
		queue_request(ACT_INSERT, 4'd7, 4'd7, IKIND_FRIEND, 1'b0);
		queue_request(ACT_CHECK, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);
		// Odd cycle after a clear whose vertex fields are ignored.
		queue_request(ACT_CLEAR, 4'd15, 4'd15, IKIND_SPARE, 1'b0);
		queue_request(ACT_INSERT, 4'd1, 4'd2, IKIND_FRIEND, 1'b0);
		queue_request(ACT_INSERT, 4'd2, 4'd3, IKIND_FRIEND, 1'b0);
		queue_request(ACT_INSERT, 4'd3, 4'd1, IKIND_FRIEND, 1'b0);
		queue_request(ACT_CHECK, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);
		queue_request(ACT_INSERT, 4'd8, 4'd9, IKIND_ENEMY, 1'b0);

		// Strict mode with an enmity edge present.
		configure(16, 1);
		queue_request(ACT_CHECK, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);

		// Small count: out-of-range inserts, and the enmity edge falls outside.
		configure(5, 1);
		queue_request(ACT_INSERT, 4'd5, 4'd1, IKIND_FRIEND, 1'b0);
		queue_request(ACT_INSERT, 4'd1, 4'd15, IKIND_FRIEND, 1'b0);
		queue_request(ACT_CHECK, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);

		// No vertices in use.
		configure(0, 0);
		queue_request(ACT_INSERT, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);
		queue_request(ACT_CHECK, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);

		// A count above the maximum behaves as the maximum.
		configure(31, 0);
		queue_request(ACT_CHECK, 4'd0, 4'd0, IKIND_FRIEND, 1'b0);

		// Random phases, each with its own setting and one of four idling patterns.
		for (int p = 0; p < PHASES; p++) begin
			int target;
			configure(phase_sizes[p], phase_strict[p]);
			sender_idle = idle_send[p % 4];
			receiver_stall = idle_recv[p % 4];
			target = requests_queued + PHASE_ITEMS;
			while (requests_queued < target)
				queue_burst(active_vertices());
		end

		settle();
		repeat (20) @(posedge clk);
		if (awaited_verdicts.size() != 0)
			report_mismatch($sformatf("%0d predictions never matched by a result",
				awaited_verdicts.size()));
		if (error_count == 0)
			$display("graph_bipartite_checker_top_tb passed");
		else
			$display("graph_bipartite_checker_top_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
